>>> rtl/brake_light_window_hold_unit_macros.svh
// Assertion macros for the brake light window hold unit.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef BRAKE_LIGHT_WINDOW_HOLD_UNIT_MACROS_SVH
`define BRAKE_LIGHT_WINDOW_HOLD_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that a condition holds at every clock edge out of reset.
`define BLWH_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("blwh assertion failed");

// Check that a cause implies an effect on the same edge.
`define BLWH_ASSERT_IMPL(lbl, cause, effect) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cause) |-> (effect)) \
    else $error("blwh implication failed");

`else

`define BLWH_ASSERT(lbl, cond)
`define BLWH_ASSERT_IMPL(lbl, cause, effect)

`endif

`endif

>>> rtl/blwh_pkg.sv
package blwh_pkg;

  // Parameter defaults
  localparam int WINDOW_LEN_DEF  = 20;
  localparam int SAMPLE_BITS_DEF = 10;

  // Fixed field widths
  localparam int MEAN_W   = 10;
  localparam int THRESH_W = 10;
  localparam int LEVEL_W  = 8;
  localparam int TIMER_W  = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Result packing: mean, in_window, light_on, light_level, send_now
  localparam int RES_BITS   = MEAN_W + 1 + 1 + LEVEL_W + 1;
  localparam int RES_DATA_W = ((RES_BITS + 7) / 8) * 8;

  // Reset values of the configuration registers
  localparam logic [THRESH_W-1:0] WIN_LOW_RST  = THRESH_W'(165);
  localparam logic [THRESH_W-1:0] WIN_HIGH_RST = THRESH_W'(510);
  localparam logic [LEVEL_W-1:0]  BRIGHT_RST   = LEVEL_W'(150);
  localparam logic [TIMER_W-1:0]  HOLD_RST     = TIMER_W'(200);
  localparam logic [TIMER_W-1:0]  SEND_RST     = TIMER_W'(100);

  // Input command codes carried on tuser
  typedef enum logic {
    CMD_TICK   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LOW  = 3'd0,
    CFG_WINDOW_HIGH = 3'd1,
    CFG_BRIGHTNESS  = 3'd2,
    CFG_HOLD_MS     = 3'd3,
    CFG_SEND_MS     = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic               send_now;
    logic [LEVEL_W-1:0] light_level;
    logic               light_on;
    logic               in_window;
    logic [MEAN_W-1:0]  mean_value;
  } result_t;

endpackage

>>> rtl/brake_light_window_hold_unit.sv
// Brake light window comparator with hold.
//
// Input stream (s_axis_*): tuser carries the command (0 = one millisecond
// tick, 1 = new sample), tdata carries the raw pressure sample in its low
// bits. A sample transfer gives exactly one result transfer; a tick gives
// none and only advances the hold and send timers (both saturate at 65535).
// Output stream (m_axis_*): mean of the sample window, in-window flag, lamp
// state, PWM level and the send flag, packed in tdata.
// Throughput is one transfer per clock while the skid entry is empty: the
// window sum is updated in the input stage, and the divide-by-length
// multiply, compare and lamp/timer update sit in the result stage. A sample's
// sum is registered in the stage register, and its result in the output
// register before it is offered. A result register plus one skid entry decouple the two
// sides; s_axis_tready only drops while the skid entry is full, i.e. after
// the receiver has stalled with a result pending and another one arrived.
// Reset clears the sample window, the running sum, both timers and the lamp,
// and loads the threshold, brightness, hold and send period defaults.
// Configuration writes (cfg_*) are taken every clock and belong to idle time.
module brake_light_window_hold_unit #(
  parameter int WINDOW_LEN  = blwh_pkg::WINDOW_LEN_DEF,
  parameter int SAMPLE_BITS = blwh_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // tdata: [SAMPLE_BITS-1:0] sample, zero padded to whole bytes
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,
  // tuser: [0] cmd
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: [9:0] mean_value, [10] in_window, [11] light_on,
  //        [19:12] light_level, [20] send_now, upper bits zero
  output logic [blwh_pkg::RES_DATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [blwh_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [blwh_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  import blwh_pkg::*;

  `include "brake_light_window_hold_unit_macros.svh"

  localparam int SLOT_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int LOG_LEN = $clog2(WINDOW_LEN);
  // The sum of a full window fits in SUM_W bits
  localparam int SUM_W   = SAMPLE_BITS + LOG_LEN;
  // Exact division by WINDOW_LEN: floor(sum * RECIP / 2^SHIFT)
  localparam int SHIFT   = SUM_W + LOG_LEN;
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));
  localparam int CMP_W   = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;
  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

  // Configuration registers
  logic [THRESH_W-1:0] win_low_q, win_high_q;
  logic [LEVEL_W-1:0]  bright_q;
  logic [TIMER_W-1:0]  hold_ms_q, send_ms_q;

  // Input stage: sample ring and running sum
  logic [SAMPLE_BITS-1:0] ring_q [WINDOW_LEN];
  logic [SLOT_W-1:0]      slot_q, slot_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   in_xfer, in_sample;

  // Stage register between the sum update and the compare
  logic             p_valid_q;
  logic             p_cmd_q;
  logic [SUM_W-1:0] p_sum_q;

  // Result stage state
  logic [TIMER_W-1:0] hold_q, hold_d;
  logic [TIMER_W-1:0] send_q, send_d;
  logic               lamp_q, lamp_d;

  logic               advance;
  logic               res_valid;
  logic [PROD_W-1:0]  prod;
  logic [CMP_W-1:0]   mean_ext;
  logic               in_win;
  logic               send_flag;
  result_t            res;

  // Output register and skid entry
  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q;
  logic    out_take;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_low_q  <= WIN_LOW_RST;
      win_high_q <= WIN_HIGH_RST;
      bright_q   <= BRIGHT_RST;
      hold_ms_q  <= HOLD_RST;
      send_ms_q  <= SEND_RST;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_WINDOW_LOW:  win_low_q  <= cfg_data_i[THRESH_W-1:0];
        CFG_WINDOW_HIGH: win_high_q <= cfg_data_i[THRESH_W-1:0];
        CFG_BRIGHTNESS:  bright_q   <= cfg_data_i[LEVEL_W-1:0];
        CFG_HOLD_MS:     hold_ms_q  <= cfg_data_i[TIMER_W-1:0];
        CFG_SEND_MS:     send_ms_q  <= cfg_data_i[TIMER_W-1:0];
        default: ; // drop writes to unused indexes
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input stage: replace the oldest sample and update the sum
  // ---------------------------------------------------------------------------
  // The whole pipe moves unless the skid entry holds a result.
  assign advance       = !skid_valid_q;
  assign s_axis_tready = advance;
  assign in_xfer       = s_axis_tvalid && advance;
  assign in_sample     = in_xfer && (cmd_e'(s_axis_tuser) == CMD_SAMPLE);
  assign sample        = s_axis_tdata[SAMPLE_BITS-1:0];

  always_comb begin
    sum_d  = sum_q - SUM_W'(ring_q[slot_q]) + SUM_W'(sample);
    slot_d = (slot_q == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_q + SLOT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        ring_q[i] <= '0;
      end
      slot_q <= '0;
      sum_q  <= '0;
    end else if (in_sample) begin
      ring_q[slot_q] <= sample;
      slot_q         <= slot_d;
      sum_q          <= sum_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (advance) begin
      p_valid_q <= s_axis_tvalid;
    end
  end

  // Payload of the stage register needs no reset
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      p_cmd_q <= s_axis_tuser;
      p_sum_q <= (cmd_e'(s_axis_tuser) == CMD_SAMPLE) ? sum_d : sum_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Result stage: mean, window compare, lamp hold and send pacing
  // ---------------------------------------------------------------------------
  assign prod     = PROD_W'(p_sum_q) * PROD_W'(RECIP);
  assign mean_ext = CMP_W'(prod[SHIFT +: SAMPLE_BITS]);
  assign in_win   = (mean_ext >= CMP_W'(win_low_q)) && (mean_ext <= CMP_W'(win_high_q));

  always_comb begin
    hold_d    = hold_q;
    send_d    = send_q;
    lamp_d    = lamp_q;
    send_flag = 1'b0;
    if (p_valid_q) begin
      if (cmd_e'(p_cmd_q) == CMD_TICK) begin
        // advance both timers, saturating
        if (hold_q != TIMER_MAX) hold_d = hold_q + TIMER_W'(1);
        if (send_q != TIMER_MAX) send_d = send_q + TIMER_W'(1);
      end else if (in_win) begin
        hold_d = '0;
        lamp_d = 1'b1;
        if (send_q > send_ms_q) begin
          send_flag = 1'b1;
          send_d    = '0;
        end
      end else if (hold_q > hold_ms_q) begin
        lamp_d = 1'b0;
      end
    end
  end

  always_comb begin
    res.mean_value  = mean_ext[MEAN_W-1:0];
    res.in_window   = in_win;
    res.light_on    = lamp_d;
    res.light_level = lamp_d ? bright_q : '0;
    res.send_now    = send_flag;
  end

  assign res_valid = advance && p_valid_q && (cmd_e'(p_cmd_q) == CMD_SAMPLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= '0;
      send_q <= '0;
      lamp_q <= 1'b0;
    end else if (advance) begin
      hold_q <= hold_d;
      send_q <= send_d;
      lamp_q <= lamp_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register with one skid entry
  // ---------------------------------------------------------------------------
  assign out_take = out_valid_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_take || !out_valid_q) begin
        out_valid_q  <= skid_valid_q || res_valid;
        skid_valid_q <= 1'b0;
      end else if (res_valid) begin
        // receiver stalled: park the new result
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take || !out_valid_q) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = RES_DATA_W'(out_q);

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `BLWH_ASSERT(a_skid_behind_out, !skid_valid_q || out_valid_q)
  `BLWH_ASSERT(a_slot_in_range, slot_q <= SLOT_W'(WINDOW_LEN - 1))
  `BLWH_ASSERT_IMPL(a_inside_lights, out_valid_q && out_q.in_window, out_q.light_on)
  `BLWH_ASSERT_IMPL(a_send_needs_inside, out_valid_q && out_q.send_now, out_q.in_window)

endmodule
